FILE: hw/rtl/dlqf_pkg.sv
// Package for the diagnostic link query framer: sizes, codes, state types
// and the structs passed between the framer, the reply checker and the top.
// No dependencies.
package dlqf_pkg;

  // Capacity of the address store for a multi-address read.
  localparam int MAX_ADDRESSES = 16;

  localparam int ADDR_IDX_W = (MAX_ADDRESSES > 1) ? $clog2(MAX_ADDRESSES) : 1;
  localparam int COUNT_W    = $clog2(MAX_ADDRESSES + 1);

  // Frame layout.
  localparam int HEADER_LEN      = 6;
  localparam int BLOCK_FRAME_LEN = 11;
  localparam int BLOCK_SIZE_BYTE = 6;
  localparam int MULTI_LEN       = 3 * MAX_ADDRESSES + HEADER_LEN + 1;
  localparam int MAX_FRAME_LEN   = (MULTI_LEN > BLOCK_FRAME_LEN) ? MULTI_LEN : BLOCK_FRAME_LEN;
  localparam int POS_W           = $clog2(MAX_FRAME_LEN);
  localparam int ECHO_W          = $clog2(MAX_FRAME_LEN + 1);

  // Byte positions inside a frame.
  localparam int POS_INIT    = 0;
  localparam int POS_DEST    = 1;
  localparam int POS_SRC     = 2;
  localparam int POS_SIZE    = 3;
  localparam int POS_CMD     = 4;
  localparam int POS_PAD     = 5;
  localparam int POS_BLK_HI  = 6;
  localparam int POS_BLK_MID = 7;
  localparam int POS_BLK_LO  = 8;
  localparam int POS_BLK_CNT = 9;

  // Reply header positions.
  localparam logic [7:0] RX_POS_DEST = 8'd1;
  localparam logic [7:0] RX_POS_SIZE = 8'd3;
  localparam logic [7:0] RX_POS_CMD  = 8'd4;

  // Highest valid 24-bit address.
  localparam logic [23:0] ADDR_MAX = 24'hFFFFFF;

  // Input commands.
  localparam logic [1:0] CMD_ADD_ADDR   = 2'd0;
  localparam logic [1:0] CMD_BLOCK_READ = 2'd1;
  localparam logic [1:0] CMD_RX_BYTE    = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_REJECTED  = 2'd1;
  localparam logic [1:0] STAT_WRONG_DST = 2'd2;
  localparam logic [1:0] STAT_BAD_SUM   = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_INIT_BYTE    = 3'd0;
  localparam logic [2:0] CFG_UNIT_ADDRESS = 3'd1;
  localparam logic [2:0] CFG_TOOL_ADDRESS = 3'd2;
  localparam logic [2:0] CFG_MULTI_OPCODE = 3'd3;
  localparam logic [2:0] CFG_BLOCK_OPCODE = 3'd4;

  // Configuration reset values.
  localparam logic [7:0] RST_INIT_BYTE    = 8'h80;
  localparam logic [7:0] RST_UNIT_ADDRESS = 8'h10;
  localparam logic [7:0] RST_TOOL_ADDRESS = 8'hF0;
  localparam logic [7:0] RST_MULTI_OPCODE = 8'hA8;
  localparam logic [7:0] RST_BLOCK_OPCODE = 8'hA0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FRAME,
    ST_REJECT,
    ST_RX
  } ctrl_state_t;

  typedef enum logic [2:0] {
    RX_IDLE,
    RX_ECHO,
    RX_HEAD,
    RX_DATA,
    RX_SUM
  } rx_phase_t;

  typedef struct packed {
    logic [7:0] init_byte;
    logic [7:0] unit_address;
    logic [7:0] tool_address;
    logic [7:0] multi_read_opcode;
    logic [7:0] block_read_opcode;
  } cfg_t;

  typedef struct packed {
    logic               start;
    logic               multi;
    logic [COUNT_W-1:0] n;
    logic [23:0]        addr;
    logic [7:0]         count_m1;
  } frm_start_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] value;
    logic [1:0] status;
  } rx_result_t;

endpackage

FILE: hw/rtl/diag_link_query_framer_core.sv
// Top level of the diagnostic link query framer: command dispatch, the
// output register and the configuration registers. Depends on dlqf_pkg,
// dlqf_addr_store, dlqf_tx_framer and dlqf_rx_checker.
//
//   Channel  Direction  Handshake             Payload
//   -------  ---------  --------------------  ----------------------------------------
//   input    in         in_valid / in_stall   cmd, address, block_count,
//                                             last_address, rx_byte
//   output   out        out_valid / out_stall kind, byte_value, status, last
//   config   in         cfg_write             cfg_index, cfg_data (write only)
//
// An address that does not close a multi read is stored and the input stays ready.
// A received byte is first accepted into a holding register and then parsed against
// the reply state. A rejected block read yields a rejected status result. A query
// frame is accepted and then sent (3n+7 bytes for n addresses, 11 for a block read),
// paced by the frame sequencer that emits one byte a cycle into the output register.
// A stall on the output holds the sequencer; a new item is still accepted while the
// final result of the previous one waits in the output register.
// Reset is synchronous and returns the configuration registers to their defaults,
// empties the address list and leaves no reply outstanding. The address store
// itself is not cleared; its entries are written before they are read.
module diag_link_query_framer_core (
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [23:0] address,
  input  logic [7:0]  block_count,
  input  logic        last_address,
  input  logic [7:0]  rx_byte,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  byte_value,
  output logic [1:0]  status,
  output logic        last,

  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int CW = dlqf_pkg::COUNT_W;
  localparam int IW = dlqf_pkg::ADDR_IDX_W;

  dlqf_pkg::ctrl_state_t state;
  dlqf_pkg::ctrl_state_t state_next;
  dlqf_pkg::cfg_t        cfg;

  logic          in_fire;
  logic          slot_free;
  logic [CW-1:0] stored_count;
  logic [CW-1:0] count_inc;
  logic          list_done;
  logic          block_reject;
  logic [24:0]   block_end;
  logic [7:0]    rx_held;

  // Address store ports.
  logic          mem_we;
  logic [IW-1:0] mem_raddr;
  logic [23:0]   mem_rdata;

  // Framer and reply checker hookup.
  dlqf_pkg::frm_start_t        frm_start;
  logic                        frm_advance;
  logic [7:0]                  frm_byte;
  logic                        frm_last;
  logic                        rx_step;
  dlqf_pkg::rx_result_t        rx_result;
  dlqf_pkg::rx_phase_t         rx_phase;

  // Output register inputs.
  logic       out_load;
  logic [1:0] kind_next;
  logic [7:0] byte_value_next;
  logic [1:0] status_next;
  logic       last_next;

  assign in_fire   = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign count_inc = stored_count + 1'b1;
  // The address that fills the store closes the list like a marked last one.
  assign list_done = last_address || (count_inc == CW'(dlqf_pkg::MAX_ADDRESSES));
  assign block_end = {1'b0, address} + {17'd0, block_count};
  assign block_reject = (block_count == 8'd0) || (block_end > {1'b0, dlqf_pkg::ADDR_MAX});

  dlqf_addr_store u_addr_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (stored_count[IW-1:0]),
    .wdata (address),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  dlqf_tx_framer u_tx_framer (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (frm_start),
    .advance   (frm_advance),
    .rd_addr   (mem_raddr),
    .rd_data   (mem_rdata),
    .tx_byte   (frm_byte),
    .tx_last   (frm_last)
  );

  // The reply checker is armed when a frame starts, so a pending reply from
  // an earlier query is dropped at that point.
  dlqf_rx_checker u_rx_checker (
    .clk          (clk),
    .rst          (rst),
    .arm          (frm_start.start),
    .arm_len      (dlqf_pkg::ECHO_W'(frm_start.multi
                     ? 8'({frm_start.n, 1'b0}) + 8'(frm_start.n) + 8'd7
                     : 8'(dlqf_pkg::BLOCK_FRAME_LEN))),
    .step         (rx_step),
    .rx_data      (rx_held),
    .tool_address (cfg.tool_address),
    .result       (rx_result),
    .phase        (rx_phase)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      dlqf_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (cmd)
            dlqf_pkg::CMD_ADD_ADDR:   state_next = list_done ? dlqf_pkg::ST_FRAME
                                                             : dlqf_pkg::ST_IDLE;
            dlqf_pkg::CMD_BLOCK_READ: state_next = block_reject ? dlqf_pkg::ST_REJECT
                                                                : dlqf_pkg::ST_FRAME;
            dlqf_pkg::CMD_RX_BYTE:    state_next = dlqf_pkg::ST_RX;
            default:                  state_next = dlqf_pkg::ST_IDLE;
          endcase
        end
      end
      dlqf_pkg::ST_FRAME: begin
        if (slot_free && frm_last) begin
          state_next = dlqf_pkg::ST_IDLE;
        end
      end
      dlqf_pkg::ST_REJECT: begin
        if (slot_free) begin
          state_next = dlqf_pkg::ST_IDLE;
        end
      end
      dlqf_pkg::ST_RX: begin
        if (!rx_result.valid || slot_free) begin
          state_next = dlqf_pkg::ST_IDLE;
        end
      end
      default: state_next = dlqf_pkg::ST_IDLE;
    endcase
  end

  // Control outputs and the value offered to the output register.
  always_comb begin
    in_stall        = (state != dlqf_pkg::ST_IDLE);
    mem_we          = 1'b0;
    frm_start       = '{start: 1'b0, multi: 1'b0, n: count_inc, addr: address,
                        count_m1: block_count - 8'd1};
    frm_advance     = 1'b0;
    rx_step         = 1'b0;
    out_load        = 1'b0;
    kind_next       = dlqf_pkg::KIND_TX;
    byte_value_next = 8'h00;
    status_next     = dlqf_pkg::STAT_OK;
    last_next       = 1'b0;
    case (state)
      dlqf_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (cmd)
            dlqf_pkg::CMD_ADD_ADDR: begin
              mem_we          = 1'b1;
              frm_start.start = list_done;
              frm_start.multi = 1'b1;
            end
            dlqf_pkg::CMD_BLOCK_READ: begin
              frm_start.start = !block_reject;
            end
            default: begin
              frm_start.start = 1'b0;
            end
          endcase
        end
      end
      dlqf_pkg::ST_FRAME: begin
        frm_advance     = slot_free;
        out_load        = slot_free;
        byte_value_next = frm_byte;
        last_next       = frm_last;
      end
      dlqf_pkg::ST_REJECT: begin
        out_load    = slot_free;
        kind_next   = dlqf_pkg::KIND_STATUS;
        status_next = dlqf_pkg::STAT_REJECTED;
        last_next   = 1'b1;
      end
      dlqf_pkg::ST_RX: begin
        rx_step         = !rx_result.valid || slot_free;
        out_load        = rx_result.valid && slot_free;
        kind_next       = rx_result.kind;
        byte_value_next = rx_result.value;
        status_next     = rx_result.status;
        last_next       = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= dlqf_pkg::ST_IDLE;
      stored_count <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (frm_start.start && frm_start.multi) begin
        stored_count <= '0;
      end else if (mem_we) begin
        stored_count <= count_inc;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind       <= kind_next;
      byte_value <= byte_value_next;
      status     <= status_next;
      last       <= last_next;
    end
    if (in_fire) begin
      rx_held <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{init_byte:         dlqf_pkg::RST_INIT_BYTE,
               unit_address:      dlqf_pkg::RST_UNIT_ADDRESS,
               tool_address:      dlqf_pkg::RST_TOOL_ADDRESS,
               multi_read_opcode: dlqf_pkg::RST_MULTI_OPCODE,
               block_read_opcode: dlqf_pkg::RST_BLOCK_OPCODE};
    end else if (cfg_write) begin
      case (cfg_index)
        dlqf_pkg::CFG_INIT_BYTE:    cfg.init_byte         <= cfg_data;
        dlqf_pkg::CFG_UNIT_ADDRESS: cfg.unit_address      <= cfg_data;
        dlqf_pkg::CFG_TOOL_ADDRESS: cfg.tool_address      <= cfg_data;
        dlqf_pkg::CFG_MULTI_OPCODE: cfg.multi_read_opcode <= cfg_data;
        dlqf_pkg::CFG_BLOCK_OPCODE: cfg.block_read_opcode <= cfg_data;
        default:                    cfg <= cfg;
      endcase
    end
  end

  // The address list never grows past the store.
  assert property (@(posedge clk) disable iff (rst)
    stored_count < CW'(dlqf_pkg::MAX_ADDRESSES))
    else $error("address list overran the store");

  // The closing byte of a frame goes out while the checker waits for the echo.
  assert property (@(posedge clk) disable iff (rst)
    (state == dlqf_pkg::ST_FRAME && out_load && frm_last) |-> rx_phase == dlqf_pkg::RX_ECHO)
    else $error("reply checker not waiting for echo at end of frame");

  // A received byte is never parsed in the cycle a new frame starts.
  assert property (@(posedge clk) disable iff (rst)
    !(rx_step && frm_start.start))
    else $error("reply parse overlaps frame start");

  // Status results carry no byte and always close the item.
  assert property (@(posedge clk) disable iff (rst)
    (out_load && kind_next == dlqf_pkg::KIND_STATUS) |=> (byte_value == 8'h00 && last))
    else $error("status result with a byte or without last");

endmodule

FILE: hw/rtl/dlqf_addr_store.sv
// Address store of the framer: a single-port-write, single-port-read memory
// with a registered read. Depends on dlqf_pkg.
module dlqf_addr_store (
  input  logic                            clk,
  input  logic                            we,
  input  logic [dlqf_pkg::ADDR_IDX_W-1:0] waddr,
  input  logic [23:0]                     wdata,
  input  logic [dlqf_pkg::ADDR_IDX_W-1:0] raddr,
  output logic [23:0]                     rdata
);

  logic [23:0] mem [dlqf_pkg::MAX_ADDRESSES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/dlqf_tx_framer.sv
// Query frame sequencer: walks a frame byte by byte, reading stored
// addresses from the address store and summing the checksum. Depends on dlqf_pkg.
module dlqf_tx_framer (
  input  logic                            clk,
  input  logic                            rst,
  input  dlqf_pkg::cfg_t                  cfg,
  input  dlqf_pkg::frm_start_t            start,
  input  logic                            advance,
  output logic [dlqf_pkg::ADDR_IDX_W-1:0] rd_addr,
  input  logic [23:0]                     rd_data,
  output logic [7:0]                      tx_byte,
  output logic                            tx_last
);

  localparam int PW = dlqf_pkg::POS_W;
  localparam int IW = dlqf_pkg::ADDR_IDX_W;

  logic          multi;
  logic [PW-1:0] pos;
  logic [PW-1:0] last_pos;
  logic [7:0]    size_byte;
  logic [7:0]    sum;
  logic [IW-1:0] idx;
  logic [IW-1:0] idx_next;
  logic [1:0]    sub;
  logic [23:0]   blk_addr;
  logic [7:0]    blk_count_m1;
  logic [7:0]    n3;
  logic          in_addr_bytes;

  assign n3            = 8'({start.n, 1'b0}) + 8'(start.n);
  assign in_addr_bytes = multi && (pos >= PW'(dlqf_pkg::HEADER_LEN)) && !tx_last;
  assign tx_last       = (pos == last_pos);

  // Read the next entry ahead of its bytes; during the header the read repeats,
  // so an entry written when the frame starts is seen by the address bytes.
  always_comb begin
    idx_next = idx;
    if (start.start) begin
      idx_next = '0;
    end else if (advance && in_addr_bytes && sub == 2'd2) begin
      idx_next = idx + 1'b1;
    end
  end
  assign rd_addr = idx_next;

  always_comb begin
    tx_byte = 8'h00;
    if (tx_last) begin
      tx_byte = sum;
    end else if (in_addr_bytes) begin
      case (sub)
        2'd0:    tx_byte = rd_data[23:16];
        2'd1:    tx_byte = rd_data[15:8];
        2'd2:    tx_byte = rd_data[7:0];
        default: tx_byte = 8'h00;
      endcase
    end else begin
      case (pos)
        PW'(dlqf_pkg::POS_INIT):    tx_byte = cfg.init_byte;
        PW'(dlqf_pkg::POS_DEST):    tx_byte = cfg.unit_address;
        PW'(dlqf_pkg::POS_SRC):     tx_byte = cfg.tool_address;
        PW'(dlqf_pkg::POS_SIZE):    tx_byte = size_byte;
        PW'(dlqf_pkg::POS_CMD):     tx_byte = multi ? cfg.multi_read_opcode
                                                    : cfg.block_read_opcode;
        PW'(dlqf_pkg::POS_PAD):     tx_byte = 8'h00;
        PW'(dlqf_pkg::POS_BLK_HI):  tx_byte = blk_addr[23:16];
        PW'(dlqf_pkg::POS_BLK_MID): tx_byte = blk_addr[15:8];
        PW'(dlqf_pkg::POS_BLK_LO):  tx_byte = blk_addr[7:0];
        PW'(dlqf_pkg::POS_BLK_CNT): tx_byte = blk_count_m1;
        default:                    tx_byte = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      last_pos <= '0;
      sum      <= '0;
      idx      <= '0;
      sub      <= '0;
      multi    <= 1'b0;
    end else if (start.start) begin
      pos      <= '0;
      sum      <= '0;
      idx      <= '0;
      sub      <= '0;
      multi    <= start.multi;
      last_pos <= start.multi ? PW'(n3 + 8'd6) : PW'(dlqf_pkg::BLOCK_FRAME_LEN - 1);
    end else if (advance) begin
      pos <= pos + 1'b1;
      sum <= sum + tx_byte;
      idx <= idx_next;
      if (in_addr_bytes) begin
        sub <= (sub == 2'd2) ? 2'd0 : sub + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start.start) begin
      size_byte    <= start.multi ? n3 + 8'd2 : 8'(dlqf_pkg::BLOCK_SIZE_BYTE);
      blk_addr     <= start.addr;
      blk_count_m1 <= start.count_m1;
    end
  end

endmodule

FILE: hw/rtl/dlqf_rx_checker.sv
// Reply parser: skips the line echo, checks the reply destination and
// checksum, and passes data bytes through. Depends on dlqf_pkg.
module dlqf_rx_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        arm,
  input  logic [dlqf_pkg::ECHO_W-1:0] arm_len,
  input  logic                        step,
  input  logic [7:0]                  rx_data,
  input  logic [7:0]                  tool_address,
  output dlqf_pkg::rx_result_t        result,
  output dlqf_pkg::rx_phase_t         phase
);

  dlqf_pkg::rx_phase_t         phase_next;
  logic [7:0]                  index;
  logic [7:0]                  index_next;
  logic [7:0]                  reply_size;
  logic [7:0]                  reply_size_next;
  logic [7:0]                  reply_sum;
  logic [7:0]                  reply_sum_next;
  logic [dlqf_pkg::ECHO_W-1:0] echo_length;
  logic [8:0]                  index_inc;

  assign index_inc = {1'b0, index} + 9'd1;

  always_comb begin
    phase_next      = phase;
    index_next      = index;
    reply_size_next = reply_size;
    reply_sum_next  = reply_sum;
    result          = '{valid: 1'b0, kind: dlqf_pkg::KIND_STATUS,
                        value: 8'h00, status: dlqf_pkg::STAT_OK};
    case (phase)
      dlqf_pkg::RX_ECHO: begin
        index_next = index_inc[7:0];
        if (index_inc >= 9'(echo_length)) begin
          phase_next     = dlqf_pkg::RX_HEAD;
          index_next     = 8'd0;
          reply_sum_next = 8'd0;
        end
      end
      dlqf_pkg::RX_HEAD: begin
        reply_sum_next = reply_sum + rx_data;
        if (index == dlqf_pkg::RX_POS_DEST && rx_data != tool_address) begin
          phase_next    = dlqf_pkg::RX_IDLE;
          result.valid  = 1'b1;
          result.status = dlqf_pkg::STAT_WRONG_DST;
        end else if (index == dlqf_pkg::RX_POS_CMD) begin
          index_next = 8'd0;
          phase_next = (reply_size > 8'd1) ? dlqf_pkg::RX_DATA : dlqf_pkg::RX_SUM;
        end else begin
          if (index == dlqf_pkg::RX_POS_SIZE) begin
            // A size of zero counts as the command byte alone.
            reply_size_next = (rx_data == 8'd0) ? 8'd1 : rx_data;
          end
          index_next = index_inc[7:0];
        end
      end
      dlqf_pkg::RX_DATA: begin
        reply_sum_next = reply_sum + rx_data;
        index_next     = index_inc[7:0];
        if ({1'b0, index_inc[7:0]} + 9'd1 >= {1'b0, reply_size}) begin
          phase_next = dlqf_pkg::RX_SUM;
        end
        result.valid = 1'b1;
        result.kind  = dlqf_pkg::KIND_DATA;
        result.value = rx_data;
      end
      dlqf_pkg::RX_SUM: begin
        phase_next    = dlqf_pkg::RX_IDLE;
        result.valid  = 1'b1;
        result.status = (rx_data == reply_sum) ? dlqf_pkg::STAT_OK : dlqf_pkg::STAT_BAD_SUM;
      end
      default: begin
        phase_next = phase;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= dlqf_pkg::RX_IDLE;
      index       <= '0;
      reply_size  <= '0;
      reply_sum   <= '0;
      echo_length <= '0;
    end else if (arm) begin
      phase       <= dlqf_pkg::RX_ECHO;
      index       <= '0;
      reply_size  <= '0;
      reply_sum   <= '0;
      echo_length <= arm_len;
    end else if (step) begin
      phase      <= phase_next;
      index      <= index_next;
      reply_size <= reply_size_next;
      reply_sum  <= reply_sum_next;
    end
  end

endmodule
